// ----- hw/rtl/vector_cosine_similarity_top_macros.svh -----
// assertion helpers for the cosine similarity block
`ifndef VECTOR_COSINE_SIMILARITY_TOP_MACROS_SVH
`define VECTOR_COSINE_SIMILARITY_TOP_MACROS_SVH

// same-cycle implication
`define VCS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define VCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/vcs_pkg.sv -----
package vcs_pkg;

   localparam int ELEM_W = 16;
   localparam int SUM_W  = 48;
   localparam int PROD_W = 2 * SUM_W;

   typedef struct packed {
      logic [SUM_W-1:0] dot;
      logic [SUM_W-1:0] norm_a;
      logic [SUM_W-1:0] norm_b;
   } vcs_sums_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic full;
      logic valid;
   } vcs_queue_ctl_type;

endpackage

// ----- hw/rtl/vcs_front.sv -----
module vcs_front
   import vcs_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [ELEM_W-1:0] req_elem_a,
   input  logic signed [ELEM_W-1:0] req_elem_b,
   input  logic                     req_last_element,
   input  logic                     q_full,
   output logic                     push,
   output vcs_sums_type             push_data
);

   logic                    p_valid_ff, p_valid_in;
   logic                    p_last_ff;
   logic signed [31:0]      p_dot_ff;
   logic        [30:0]      p_na_ff;
   logic        [30:0]      p_nb_ff;
   logic signed [31:0]      dot_prod;
   logic signed [31:0]      na_prod;
   logic signed [31:0]      nb_prod;
   logic [SUM_W-1:0]        dot_ff, dot_in;
   logic [SUM_W-1:0]        na_ff, na_in;
   logic [SUM_W-1:0]        nb_ff, nb_in;
   logic                    accept;
   logic                    advance;

   assign dot_prod = req_elem_a * req_elem_b;
   assign na_prod  = req_elem_a * req_elem_a;
   assign nb_prod  = req_elem_b * req_elem_b;

   assign req_stall = p_valid_ff && p_last_ff && q_full;
   assign accept    = req_valid && !req_stall;
   assign advance   = p_valid_ff && !(p_last_ff && q_full);

   assign dot_in = dot_ff + {{(SUM_W-32){p_dot_ff[31]}}, p_dot_ff};
   assign na_in  = na_ff + {{(SUM_W-31){1'b0}}, p_na_ff};
   assign nb_in  = nb_ff + {{(SUM_W-31){1'b0}}, p_nb_ff};

   assign push             = advance && p_last_ff;
   assign push_data.dot    = dot_in;
   assign push_data.norm_a = na_in;
   assign push_data.norm_b = nb_in;

   always_comb begin
      p_valid_in = p_valid_ff;
      if (accept) begin
         p_valid_in = 1'b1;
      end else if (advance) begin
         p_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         p_last_ff <= req_last_element;
         p_dot_ff  <= dot_prod;
         p_na_ff   <= na_prod[30:0];
         p_nb_ff   <= nb_prod[30:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         dot_ff     <= '0;
         na_ff      <= '0;
         nb_ff      <= '0;
      end else begin
         p_valid_ff <= p_valid_in;
         if (advance) begin
            if (p_last_ff) begin
               dot_ff <= '0;
               na_ff  <= '0;
               nb_ff  <= '0;
            end else begin
               dot_ff <= dot_in;
               na_ff  <= na_in;
               nb_ff  <= nb_in;
            end
         end
      end
   end

endmodule

// ----- hw/rtl/vcs_queue.sv -----
module vcs_queue
   import vcs_pkg::*;
#(
   parameter int DEPTH = 2
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  vcs_sums_type push_data,
   input  logic         pop,
   output logic         full,
   output logic         valid,
   output vcs_sums_type head_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   vcs_sums_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]        count_ff, count_in;

   assign full      = (count_ff == FULL_CNT);
   assign valid     = (count_ff != '0);
   assign head_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- hw/rtl/vcs_back.sv -----
module vcs_back
   import vcs_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_valid,
   input  vcs_sums_type             q_data,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [ELEM_W-1:0] rsp_similarity,
   output logic                     rsp_zero_norm
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MUL   = 3'd1;
   localparam logic [2:0] ST_SQRT  = 3'd2;
   localparam logic [2:0] ST_CHECK = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;
   localparam logic [2:0] ST_WAIT  = 3'd5;

   localparam int HALF_W = SUM_W / 2;
   localparam int REM_W  = SUM_W + 2;
   localparam int Q_W    = ELEM_W - 1;
   localparam logic [5:0] MUL_LAST  = 6'd4;
   localparam logic [5:0] SQRT_LAST = 6'(SUM_W - 1);
   localparam logic [5:0] DIV_LAST  = 6'(Q_W - 1);
   localparam logic [ELEM_W-1:0] SAT_POS = {1'b0, {(ELEM_W-1){1'b1}}};
   localparam logic [ELEM_W-1:0] SAT_NEG = {1'b1, {(ELEM_W-1){1'b0}}};

   logic [2:0]              state_ff;
   logic [5:0]              cnt_ff;
   logic                    neg_ff;
   logic                    zero_ff;
   logic [SUM_W-1:0]        na_ff;
   logic [SUM_W-1:0]        nb_ff;
   logic [SUM_W-1:0]        mag_ff;
   logic [SUM_W-1:0]        mag_in;
   logic [2*HALF_W-1:0]     pp_ff, pp_in;
   logic [1:0]              pp_sh_ff;
   logic [PROD_W-1:0]       prod_ff;
   logic [PROD_W-1:0]       pp_term;
   logic [REM_W-1:0]        rem_ff;
   logic [SUM_W-1:0]        root_ff;
   logic [REM_W+1:0]        rem_sh;
   logic [REM_W+1:0]        trial;
   logic [SUM_W:0]          div_sh;
   logic [Q_W-1:0]          q_ff;
   logic [Q_W-1:0]          q_in;
   logic [SUM_W-1:0]        div_rem_in;
   logic [ELEM_W-1:0]       res_ff;
   logic [ELEM_W-1:0]       q_ext;
   logic [HALF_W-1:0]       op_x;
   logic [HALF_W-1:0]       op_y;
   logic                    rsp_valid_ff;
   logic                    out_free;

   assign pop            = (state_ff == ST_IDLE) && q_valid;
   assign out_free       = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid      = rsp_valid_ff;
   assign mag_in         = q_data.dot[SUM_W-1] ? SUM_W'(0 - q_data.dot) : q_data.dot;

   always_comb begin
      case (cnt_ff[1:0])
         2'd0: begin
            op_x = na_ff[HALF_W-1:0];
            op_y = nb_ff[HALF_W-1:0];
         end
         2'd1: begin
            op_x = na_ff[HALF_W-1:0];
            op_y = nb_ff[SUM_W-1:HALF_W];
         end
         2'd2: begin
            op_x = na_ff[SUM_W-1:HALF_W];
            op_y = nb_ff[HALF_W-1:0];
         end
         default: begin
            op_x = na_ff[SUM_W-1:HALF_W];
            op_y = nb_ff[SUM_W-1:HALF_W];
         end
      endcase
   end

   assign pp_in = op_x * op_y;

   always_comb begin
      case (pp_sh_ff)
         2'd0:    pp_term = {{SUM_W{1'b0}}, pp_ff};
         2'd1,
         2'd2:    pp_term = {{HALF_W{1'b0}}, pp_ff, {HALF_W{1'b0}}};
         default: pp_term = {pp_ff, {SUM_W{1'b0}}};
      endcase
   end

   assign rem_sh = {rem_ff, prod_ff[PROD_W-1:PROD_W-2]};
   assign trial  = {2'b00, root_ff, 2'b01};

   always_comb begin
      div_sh = {mag_ff, 1'b0};
      if (div_sh >= {1'b0, root_ff}) begin
         div_rem_in = SUM_W'(div_sh - {1'b0, root_ff});
         q_in       = {q_ff[Q_W-2:0], 1'b1};
      end else begin
         div_rem_in = div_sh[SUM_W-1:0];
         q_in       = {q_ff[Q_W-2:0], 1'b0};
      end
      q_ext = {1'b0, q_in};
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               na_ff   <= q_data.norm_a;
               nb_ff   <= q_data.norm_b;
               neg_ff  <= q_data.dot[SUM_W-1];
               mag_ff  <= mag_in;
               zero_ff <= (q_data.norm_a == '0) || (q_data.norm_b == '0);
               res_ff  <= '0;
               prod_ff <= '0;
            end
         end
         ST_MUL: begin
            if (cnt_ff != MUL_LAST) begin
               pp_ff    <= pp_in;
               pp_sh_ff <= cnt_ff[1:0];
            end
            if (cnt_ff != '0) begin
               prod_ff <= prod_ff + pp_term;
            end
            if (cnt_ff == MUL_LAST) begin
               rem_ff  <= '0;
               root_ff <= '0;
            end
         end
         ST_SQRT: begin
            prod_ff <= {prod_ff[PROD_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
               rem_ff  <= REM_W'(rem_sh - trial);
               root_ff <= {root_ff[SUM_W-2:0], 1'b1};
            end else begin
               rem_ff  <= rem_sh[REM_W-1:0];
               root_ff <= {root_ff[SUM_W-2:0], 1'b0};
            end
         end
         ST_CHECK: begin
            q_ff <= '0;
            if (mag_ff >= root_ff) begin
               res_ff <= neg_ff ? SAT_NEG : SAT_POS;
            end
         end
         ST_DIV: begin
            mag_ff <= div_rem_in;
            q_ff   <= q_in;
            if (cnt_ff == DIV_LAST) begin
               res_ff <= neg_ff ? ELEM_W'(0 - q_ext) : q_ext;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if ((state_ff == ST_WAIT) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               cnt_ff <= '0;
               if (q_valid) begin
                  if ((q_data.norm_a == '0) || (q_data.norm_b == '0)) begin
                     state_ff <= ST_WAIT;
                  end else begin
                     state_ff <= ST_MUL;
                  end
               end
            end
            ST_MUL: begin
               if (cnt_ff == MUL_LAST) begin
                  cnt_ff   <= '0;
                  state_ff <= ST_SQRT;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ST_SQRT: begin
               if (cnt_ff == SQRT_LAST) begin
                  cnt_ff   <= '0;
                  state_ff <= ST_CHECK;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ST_CHECK: begin
               cnt_ff <= '0;
               if (mag_ff >= root_ff) begin
                  state_ff <= ST_WAIT;
               end else begin
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (cnt_ff == DIV_LAST) begin
                  cnt_ff   <= '0;
                  state_ff <= ST_WAIT;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ST_WAIT: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_WAIT) && out_free) begin
         rsp_similarity <= res_ff;
         rsp_zero_norm  <= zero_ff;
      end
   end

endmodule

// ----- hw/rtl/vector_cosine_similarity_top.sv -----
// path from the last request of a vector to its result:
// (accumulate, queue, norm product, square root, check, divide, output)
// saturated results skip the divide, zero norm results go from the queue straight to the output
// throughput: one element pair per cycle; the back end handles one vector at a time,
// so short vectors stall requests once the result queue is full
// reset: synchronous, clears sums, queue, back end state and output valid
`include "vector_cosine_similarity_top_macros.svh"

module vector_cosine_similarity_top
   import vcs_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [ELEM_W-1:0] req_elem_a,
   input  logic signed [ELEM_W-1:0] req_elem_b,
   input  logic                     req_last_element,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [ELEM_W-1:0] rsp_similarity,
   output logic                     rsp_zero_norm
);

   vcs_queue_ctl_type       qctl;
   vcs_sums_type            push_data;
   vcs_sums_type            head_data;

   vcs_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_elem_a       (req_elem_a),
      .req_elem_b       (req_elem_b),
      .req_last_element (req_last_element),
      .q_full           (qctl.full),
      .push             (qctl.push),
      .push_data        (push_data)
   );

   vcs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (qctl.push),
      .push_data (push_data),
      .pop       (qctl.pop),
      .full      (qctl.full),
      .valid     (qctl.valid),
      .head_data (head_data)
   );

   vcs_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (qctl.valid),
      .q_data         (head_data),
      .pop            (qctl.pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_similarity (rsp_similarity),
      .rsp_zero_norm  (rsp_zero_norm)
   );

   `VCS_ASSERT_NOW(a_no_push_full, clock, reset, qctl.full, !qctl.push, "push into full queue")
   `VCS_ASSERT_NOW(a_pop_valid, clock, reset, qctl.pop, qctl.valid, "pop from empty queue")
   `VCS_ASSERT_NOW(a_stall_cause, clock, reset, req_stall, qctl.full, "stall without full queue")
   `VCS_ASSERT_NOW(a_zero_sim, clock, reset, rsp_valid && rsp_zero_norm, rsp_similarity == 0, "zero norm with nonzero similarity")

endmodule

// ----- sim/tb_vector_cosine_similarity_top.sv -----
`timescale 1ns / 100ps

module tb_vector_cosine_similarity_top;
   import vcs_pkg::*;

   localparam int IDLE_LIMIT     = 5000;
   localparam int HOLD_CYCLES    = 400;
   localparam int DRAIN_CYCLES   = 100;
   localparam int RANDOM_ITEMS   = 1000;
   localparam int N_DIRECTED     = 22;

   typedef struct packed {
      logic signed [ELEM_W-1:0] similarity;
      logic                     zero_norm;
   } cos_result_type;

   typedef struct packed {
      logic signed [ELEM_W-1:0] a;
      logic signed [ELEM_W-1:0] b;
      logic                     last;
      logic                     pinned;
      logic signed [ELEM_W-1:0] similarity;
      logic                     zero_norm;
   } stim_row_type;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic signed [ELEM_W-1:0] req_elem_a;
   logic signed [ELEM_W-1:0] req_elem_b;
   logic                     req_last_element;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic signed [ELEM_W-1:0] rsp_similarity;
   logic                     rsp_zero_norm;

   logic [SUM_W-1:0] dot_acc;
   logic [SUM_W-1:0] norm_a_acc;
   logic [SUM_W-1:0] norm_b_acc;
   cos_result_type   cosine_q [$];

   int  error_count = 0;
   int  idle_cycles = 0;
   int  burst_left  = 0;
   bit  hold_off_req = 1'b0;

   vector_cosine_similarity_top uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_elem_a       (req_elem_a),
      .req_elem_b       (req_elem_b),
      .req_last_element (req_last_element),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_similarity   (rsp_similarity),
      .rsp_zero_norm    (rsp_zero_norm)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic cos_result_type cosine_of(input logic [SUM_W-1:0] dot,
                                                input logic [SUM_W-1:0] na,
                                                input logic [SUM_W-1:0] nb);
      cos_result_type    res;
      logic [PROD_W-1:0] prod;
      logic [PROD_W-1:0] sq;
      logic [SUM_W-1:0]  root;
      logic [SUM_W-1:0]  cand;
      logic [SUM_W:0]    mag;
      logic [63:0]       quo;
      logic              neg;
      res.similarity = '0;
      res.zero_norm  = 1'b0;
      if (na == '0 || nb == '0) begin
         res.zero_norm = 1'b1;
         return res;
      end
      neg  = dot[SUM_W-1];
      mag  = neg ? ((49'd1 << SUM_W) - {1'b0, dot}) : {1'b0, dot};
      prod = PROD_W'(na) * PROD_W'(nb);
      root = '0;
      for (int i = SUM_W - 1; i >= 0; i--) begin
         cand = root | (48'd1 << i);
         sq   = PROD_W'(cand) * PROD_W'(cand);
         if (sq <= prod)
            root = cand;
      end
      quo = {mag, 15'd0} / 64'(root);
      if (neg)
         res.similarity = (quo >= 64'd32768) ? 16'sh8000 : 16'(64'd0 - quo);
      else
         res.similarity = (quo > 64'd32767) ? 16'sd32767 : quo[15:0];
      return res;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch in %s: got %0d, want %0d", what, got, want);
      error_count++;
   endtask

   // offer one request, track sums on acceptance, then maybe idle
   task automatic send_pair(input logic signed [ELEM_W-1:0] a,
                            input logic signed [ELEM_W-1:0] b,
                            input logic                     last,
                            input logic                     pinned,
                            input cos_result_type           pinned_res);
      logic signed [31:0] p_ab;
      logic signed [31:0] p_aa;
      logic signed [31:0] p_bb;
      req_valid        <= 1'b1;
      req_elem_a       <= a;
      req_elem_b       <= b;
      req_last_element <= last;
      do
         @(posedge clock);
      while (req_stall);
      p_ab = a * b;
      p_aa = a * a;
      p_bb = b * b;
      dot_acc    = dot_acc + {{16{p_ab[31]}}, p_ab};
      norm_a_acc = norm_a_acc + {{16{p_aa[31]}}, p_aa};
      norm_b_acc = norm_b_acc + {{16{p_bb[31]}}, p_bb};
      if (last) begin
         cosine_q.push_back(pinned ? pinned_res : cosine_of(dot_acc, norm_a_acc, norm_b_acc));
         dot_acc    = '0;
         norm_a_acc = '0;
         norm_b_acc = '0;
      end
      if (burst_left > 0)
         burst_left--;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 9) == 0) ? 300 : $urandom_range(1, 24);
      end
   endtask

   task automatic wait_drained;
      req_valid <= 1'b0;
      while (cosine_q.size() != 0)
         @(posedge clock);
   endtask

   always @(posedge clock) begin
      if ((req_valid === 1'b1 && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && rsp_stall === 1'b0))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT)
         @(posedge clock);
      $display("TB_ERROR");
      $finish;
   end

   // result checker
   always @(posedge clock) begin
      cos_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (cosine_q.size() == 0) begin
            report_mismatch("unexpected result", rsp_similarity, 0);
         end else begin
            want = cosine_q.pop_front();
            if (rsp_similarity !== want.similarity)
               report_mismatch("similarity", rsp_similarity, want.similarity);
            if (rsp_zero_norm !== want.zero_norm)
               report_mismatch("zero_norm", rsp_zero_norm, want.zero_norm);
         end
      end
   end

   // result side stall pattern
   initial begin
      int mode;
      int mode_left;
      int tick;
      mode      = 0;
      mode_left = 0;
      tick      = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 200);
         end
         mode_left--;
         tick++;
         case (mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 9) < 3);
            2: rsp_stall <= ($urandom_range(0, 9) < 8);
            default: rsp_stall <= (tick % 3 == 0);
         endcase
      end
   end

   initial begin
      stim_row_type             directed_rows [N_DIRECTED];
      logic signed [ELEM_W-1:0] corner [6];
      logic signed [ELEM_W-1:0] a;
      logic signed [ELEM_W-1:0] b;
      cos_result_type           none;
      int                       sent;
      int                       len;
      int                       style;
      bit                       pressed;

      none    = '0;
      pressed = 1'b0;
      corner  = '{16'sh8000, -16'sd32767, -16'sd1, 16'sd0, 16'sd1, 16'sd32767};
      directed_rows = '{
         '{16'sd0,      16'sd0,      1'b1, 1'b1, 16'sd0,     1'b1},
         '{16'sd32767,  16'sd32767,  1'b1, 1'b1, 16'sd32767, 1'b0},
         '{16'sh8000,   16'sh8000,   1'b1, 1'b1, 16'sd32767, 1'b0},
         '{16'sd32767,  -16'sd32767, 1'b1, 1'b1, 16'sh8000,  1'b0},
         '{16'sh8000,   16'sd32767,  1'b1, 1'b1, 16'sh8000,  1'b0},
         '{16'sd0,      16'sd5,      1'b1, 1'b1, 16'sd0,     1'b1},
         '{16'sd5,      16'sd0,      1'b1, 1'b1, 16'sd0,     1'b1},
         '{16'sd1,      16'sd0,      1'b0, 1'b0, 16'sd0,     1'b0},
         '{16'sd0,      16'sd1,      1'b1, 1'b1, 16'sd0,     1'b0},
         '{16'sd0,      16'sd7,      1'b0, 1'b0, 16'sd0,     1'b0},
         '{16'sd0,      -16'sd3,     1'b1, 1'b1, 16'sd0,     1'b1},
         '{16'sd16384,  16'sd8192,   1'b0, 1'b0, 16'sd0,     1'b0},
         '{-16'sd100,   16'sd300,    1'b0, 1'b0, 16'sd0,     1'b0},
         '{16'sd32767,  16'sh8000,   1'b1, 1'b0, 16'sd0,     1'b0},
         '{-16'sd1,     16'sd1,      1'b1, 1'b1, 16'sh8000,  1'b0},
         '{16'sd12345,  -16'sd23456, 1'b1, 1'b0, 16'sd0,     1'b0},
         '{16'sh8000,   16'sd0,      1'b0, 1'b0, 16'sd0,     1'b0},
         '{16'sd0,      16'sh8000,   1'b1, 1'b1, 16'sd0,     1'b0},
         '{16'sd3,      16'sd4,      1'b0, 1'b0, 16'sd0,     1'b0},
         '{16'sd4,      -16'sd3,     1'b0, 1'b0, 16'sd0,     1'b0},
         '{-16'sd21845, 16'sd21845,  1'b1, 1'b0, 16'sd0,     1'b0},
         '{16'sh5555,   16'shAAAA,   1'b1, 1'b0, 16'sd0,     1'b0}
      };

      dot_acc          = '0;
      norm_a_acc       = '0;
      norm_b_acc       = '0;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_elem_a       <= '0;
      req_elem_b       <= '0;
      req_last_element <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      burst_left = $urandom_range(1, 24);

      for (int i = 0; i < N_DIRECTED; i++)
         send_pair(directed_rows[i].a, directed_rows[i].b, directed_rows[i].last,
                   directed_rows[i].pinned,
                   '{directed_rows[i].similarity, directed_rows[i].zero_norm});
      wait_drained();

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         // receiver holds off while short vectors pile up
         if (!pressed && sent > RANDOM_ITEMS / 2) begin
            pressed      = 1'b1;
            hold_off_req = 1'b1;
            for (int k = 0; k < 16; k++)
               send_pair(16'($urandom), 16'($urandom), 1'b1, 1'b0, none);
            wait_drained();
         end
         case ($urandom_range(0, 19))
            0:       len = $urandom_range(41, 200);
            1, 2, 3, 4, 5: len = $urandom_range(7, 40);
            default: len = $urandom_range(1, 6);
         endcase
         style = $urandom_range(0, 5);
         for (int k = 0; k < len; k++) begin
            case (style)
               0: begin
                  a = 16'($urandom);
                  b = 16'($urandom);
               end
               1: begin
                  a = 16'($urandom);
                  b = a;
               end
               2: begin
                  a = 16'($urandom);
                  b = -a;
               end
               3: begin
                  a = 16'($urandom_range(0, 8)) - 16'sd4;
                  b = 16'($urandom_range(0, 8)) - 16'sd4;
               end
               4: begin
                  a = corner[$urandom_range(0, 5)];
                  b = corner[$urandom_range(0, 5)];
               end
               default: begin
                  a = 16'($urandom);
                  b = (a >>> 2) + 16'($urandom_range(0, 511)) - 16'sd256;
               end
            endcase
            send_pair(a, b, k == len - 1, 1'b0, none);
         end
         sent += len;
      end
      wait_drained();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
